// ===== rtl/deq_pkg.sv =====
package deq_pkg;

	// Default sizes of the ring store.
	localparam int DEPTH_DEF       = 64;
	localparam int VALUE_WIDTH_DEF = 64;

	// Field widths of the stream payloads.
	localparam int FUNC_W   = 3;
	localparam int VALUE_W  = 64;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	// Packed stream widths, padded to whole bytes.
	localparam int IN_TDATA_W  = 72;
	localparam int OUT_TDATA_W = 144;

	// Operation codes carried in the input transaction.
	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_BACK  = 3'd0,
		FN_PUSH_FRONT = 3'd1,
		FN_POP_FRONT  = 3'd2,
		FN_POP_BACK   = 3'd3,
		FN_REVERSE    = 3'd4
	} deq_func_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} deq_status_t;

	// Controller states.
	typedef enum logic {
		S_IDLE,
		S_FETCH
	} deq_state_t;

	// One result transaction as it leaves the controller.
	typedef struct packed {
		deq_status_t          status;
		logic                 is_empty;
		logic [COUNT_W-1:0]   entry_count;
		logic [VALUE_W-1:0]   back_value;
		logic [VALUE_W-1:0]   front_value;
	} deq_result_t;

endpackage

// ===== rtl/deq_mem.sv =====
module deq_mem #(
	parameter int DEPTH = 64,
	parameter int VW    = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [VW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [VW-1:0] rdata
);

	logic [VW-1:0] mem [DEPTH];

	// Single write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port; the data appears in the cycle after re.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/deq_ctrl.sv =====
module deq_ctrl #(
	parameter int DEPTH = 64,
	parameter int VW    = 64,
	parameter int AW    = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [deq_pkg::FUNC_W-1:0]  in_func,
	input  logic [deq_pkg::VALUE_W-1:0] in_value,
	output logic                  mem_we,
	output logic [AW-1:0]         mem_waddr,
	output logic [VW-1:0]         mem_wdata,
	output logic                  mem_re,
	output logic [AW-1:0]         mem_raddr,
	input  logic [VW-1:0]         mem_rdata,
	output logic                  out_valid,
	input  logic                  out_ready,
	output deq_pkg::deq_result_t  out_result
);
	import deq_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
	localparam logic [AW-1:0] HEAD_MAX = AW'(DEPTH - 1);
	localparam logic [CW-1:0] COUNT_FULL = CW'(DEPTH);

	deq_state_t    state_q, state_d;
	logic [AW-1:0] head_q, head_d;
	logic [CW-1:0] count_q, count_d;
	logic          rev_q, rev_d;
	logic          fetch_first_q, fetch_first_d;
	logic [VW-1:0] first_q, first_d;
	logic [VW-1:0] last_q, last_d;
	logic          out_valid_q;
	deq_result_t   res_q, res_d;
	logic          load_out;
	deq_status_t   status;
	deq_func_t     func;
	logic [VW-1:0] value;
	logic          accept;
	logic          at_first;

	logic [AW-1:0] head_inc, head_dec;
	logic [SW-1:0] sum_tail, sum_last2;
	logic [AW-1:0] slot_tail, slot_last2;
	logic [VW-1:0] front_sel, back_sel;

	assign in_ready   = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign accept     = in_valid && in_ready;
	assign func       = deq_func_t'(in_func);
	assign value      = in_value[VW-1:0];
	assign out_valid  = out_valid_q;
	assign out_result = res_q;

	// Ring pointer arithmetic; each sum stays below twice the depth wherever used.
	always_comb begin
		head_inc   = (head_q == HEAD_MAX) ? '0 : head_q + AW'(1);
		head_dec   = (head_q == '0) ? HEAD_MAX : head_q - AW'(1);
		sum_tail   = SW'(head_q) + SW'(count_q);
		sum_last2  = SW'(head_q) + SW'(count_q) - SW'(2);
		slot_tail  = (sum_tail >= DEPTH_S) ? AW'(sum_tail - DEPTH_S) : AW'(sum_tail);
		slot_last2 = (sum_last2 >= DEPTH_S) ? AW'(sum_last2 - DEPTH_S) : AW'(sum_last2);
	end

	// Next state, cached end values and memory requests.
	always_comb begin
		state_d       = state_q;
		head_d        = head_q;
		count_d       = count_q;
		rev_d         = rev_q;
		fetch_first_d = fetch_first_q;
		first_d       = first_q;
		last_d        = last_q;
		status        = STAT_OK;
		load_out      = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = slot_tail;
		mem_wdata     = value;
		mem_re        = 1'b0;
		mem_raddr     = head_inc;
		at_first      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					load_out = 1'b1;
					case (func)
						FN_PUSH_BACK, FN_PUSH_FRONT: begin
							if (count_q == COUNT_FULL) begin
								status = STAT_FULL;
							end else begin
								at_first = (func == FN_PUSH_FRONT) != rev_q;
								mem_we   = 1'b1;
								count_d  = count_q + CW'(1);
								if (at_first) begin
									head_d    = head_dec;
									mem_waddr = head_dec;
									first_d   = value;
									if (count_q == '0) begin
										last_d = value;
									end
								end else begin
									mem_waddr = slot_tail;
									last_d    = value;
									if (count_q == '0) begin
										first_d = value;
									end
								end
							end
						end
						FN_POP_FRONT, FN_POP_BACK: begin
							if (count_q == '0) begin
								status = STAT_EMPTY;
							end else begin
								at_first = (func == FN_POP_FRONT) != rev_q;
								count_d  = count_q - CW'(1);
								if (at_first) begin
									head_d = head_inc;
								end
								// A new end entry must be fetched unless the queue empties.
								if (count_q != CW'(1)) begin
									load_out      = 1'b0;
									mem_re        = 1'b1;
									mem_raddr     = at_first ? head_inc : slot_last2;
									fetch_first_d = at_first;
									state_d       = S_FETCH;
								end
							end
						end
						FN_REVERSE: begin
							rev_d = !rev_q;
						end
						default: begin
						end
					endcase
				end
			end
			S_FETCH: begin
				load_out = 1'b1;
				state_d  = S_IDLE;
				if (fetch_first_q) begin
					first_d = mem_rdata;
				end else begin
					last_d = mem_rdata;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Result as seen after the operation.
	always_comb begin
		front_sel = rev_d ? last_d : first_d;
		back_sel  = rev_d ? first_d : last_d;
		if (count_d == '0) begin
			front_sel = '0;
			back_sel  = '0;
		end
		res_d.front_value = VALUE_W'(front_sel);
		res_d.back_value  = VALUE_W'(back_sel);
		res_d.entry_count = COUNT_W'(count_d);
		res_d.is_empty    = (count_d == '0);
		res_d.status      = status;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= '0;
			count_q       <= '0;
			rev_q         <= 1'b0;
			fetch_first_q <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			head_q        <= head_d;
			count_q       <= count_d;
			rev_q         <= rev_d;
			fetch_first_q <= fetch_first_d;
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers: cached end values and the output result.
	always_ff @(posedge clk) begin
		first_q <= first_d;
		last_q  <= last_d;
		if (load_out) begin
			res_q <= res_d;
		end
	end

endmodule

// ===== rtl/double_ended_queue_top.sv =====
// Bounded double-ended queue of raw words held in a ring memory.
// Input stream (s_*): one transaction per operation: push back, push front,
// pop front, pop back or reverse, with the value to push.
// Output stream (m_*): exactly one transaction per input transaction, giving
// the front value, back value, entry count, empty flag and status after the
// operation. A pop on an empty queue or a push on a full one leaves the queue
// unchanged and reports an error status.
// Pushes, reverses, error cases and a pop that empties the queue load the
// result register directly, so the result appears in the cycle after
// acceptance. A pop that leaves entries behind passes through the fetch state
// first, since the new end entry is read through the registered read port.
// One operation is in flight at a time.
// Reset clears the pointers, the count and the direction flag; the queue is
// empty and the memory needs no clearing. The result is held in an output
// register; while the receiver stalls with a result pending, s_tready stays
// low until that result is taken, and it may be taken in the same cycle as
// the next input transaction is accepted.
module double_ended_queue_top #(
	parameter int DEPTH       = deq_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = deq_pkg::VALUE_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// func [2:0], value [66:3], zero padding [71:67]
	input  logic [deq_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// front_value [63:0], back_value [127:64], entry_count [134:128],
	// is_empty [135], status [137:136], zero padding [143:138]
	output logic [deq_pkg::OUT_TDATA_W-1:0]    m_tdata
);
	import deq_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [VALUE_WIDTH-1:0] mem_wdata;
	logic                   mem_re;
	logic [AW-1:0]          mem_raddr;
	logic [VALUE_WIDTH-1:0] mem_rdata;
	deq_result_t            result;

	deq_ctrl #(
		.DEPTH (DEPTH),
		.VW    (VALUE_WIDTH),
		.AW    (AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_func    (s_tdata[FUNC_W-1:0]),
		.in_value   (s_tdata[FUNC_W+VALUE_W-1:FUNC_W]),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	deq_mem #(
		.DEPTH (DEPTH),
		.VW    (VALUE_WIDTH),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// Pack the result fields, lowest field first.
	assign m_tdata = OUT_TDATA_W'(result);

endmodule

// ===== rtl/deq_checker.sv =====
module deq_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_tvalid,
	input logic         s_tready,
	input logic         m_tvalid,
	input logic         m_tready,
	input logic [143:0] m_tdata
);
	import deq_pkg::*;

	// A stalled result holds its value until it is taken.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// An empty queue reports zero front and back values.
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[135] |-> m_tdata[127:0] == 128'd0)
		else $error("empty queue reports nonzero end values");

	// Status never goes beyond the full code.
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[137:136] <= STAT_FULL))
		else $error("unused status code");

	// A new transaction is taken only when the pending result leaves.
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && m_tvalid |-> m_tready)
		else $error("input accepted over a stalled result");

	// No result is offered during reset.
	a_reset: assert property (@(posedge clk)
		!arst_n |-> !m_tvalid)
		else $error("result valid during reset");

endmodule

bind double_ended_queue_top deq_checker u_deq_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
